// ===== src/rrts_pkg.sv =====
package rrts_pkg;

    localparam int MaxTasks = 16;
    localparam int SlotW = $clog2(MaxTasks);
    localparam int CntW = $clog2(MaxTasks + 1);

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_BLOCK = 3'd1;
    localparam logic [2:0] OP_SLEEP = 3'd2;
    localparam logic [2:0] OP_UNBLOCK = 3'd3;
    localparam logic [2:0] OP_SOFT = 3'd4;
    localparam logic [2:0] OP_SCHED = 3'd5;

    localparam logic [3:0] ST_RUNNING = 4'd0;
    localparam logic [3:0] ST_READY = 4'd1;
    localparam logic [3:0] ST_IDLE = 4'd2;
    localparam logic [3:0] ST_SLEEPING = 4'd4;

    localparam logic [2:0] STS_OK = 3'd0;
    localparam logic [2:0] STS_FULL = 3'd1;
    localparam logic [2:0] STS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STS_ALREADY = 3'd3;
    localparam logic [2:0] STS_NO_READY = 3'd4;
    localparam logic [2:0] STS_PAST = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic find_init;
        logic find_step;
        logic scan_init;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_find;
        logic need_scan;
        logic find_done;
        logic scan_done;
    } t_stat;

endpackage

// ===== src/rrts_ctrl.sv =====
module rrts_ctrl import rrts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                if (i_stat.need_find) begin
                    o_cmd.find_init = 1'b1;
                    n_state = S_FIND;
                end else if (i_stat.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FIND: begin
                o_cmd.find_step = 1'b1;
                if (i_stat.find_done) n_state = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/rrts_dp.sv =====
module rrts_dp import rrts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_task_id,
    input  logic [3:0]  i_state_code,
    input  logic [31:0] i_wake_time,
    input  logic [31:0] i_now_tick,
    output t_stat       o_stat,
    output logic [2:0]  o_status,
    output logic [15:0] o_running_id,
    output logic        o_switched,
    output logic [15:0] o_new_id
);

    logic [15:0]      r_id [MaxTasks];
    logic [3:0]       r_st [MaxTasks];
    logic [31:0]      r_wake [MaxTasks];
    logic [CntW-1:0]  r_used;
    logic [SlotW-1:0] r_cur;
    logic             r_idle;
    logic [CntW-1:0]  r_live;
    logic [15:0]      r_last;
    logic [2:0]       r_op;
    logic [15:0]      r_tid;
    logic [3:0]       r_code;
    logic [31:0]      r_wk, r_now;
    logic [2:0]       r_status;
    logic [15:0]      r_new;
    logic             r_was_idle;
    logic [SlotW-1:0] r_was_slot;
    logic [SlotW-1:0] r_pos;
    logic [CntW-1:0]  r_n;
    logic             need_find, need_scan;

    logic [CntW-1:0]  live_dn, live_up;
    logic             run_sched;
    logic [SlotW-1:0] used_m1, pos_nx, cur_after;
    logic [SlotW-1:0] used_lo;
    logic [3:0]       blk_code;

    assign used_lo = r_used[SlotW-1:0];
    assign used_m1 = SlotW'(r_used - 1'b1);
    assign live_dn = (r_live != '0) ? r_live - 1'b1 : r_live;
    assign live_up = (r_live < CntW'(MaxTasks)) ? r_live + 1'b1 : r_live;
    assign pos_nx = (r_pos == '0) ? used_m1 : r_pos - 1'b1;
    assign blk_code = (r_op == OP_SLEEP) ? ST_SLEEPING : r_code;

    assign o_stat.need_find = need_find;
    assign o_stat.need_scan = need_scan;
    assign o_stat.find_done = (r_n == '0) || (r_id[r_pos] == r_tid && r_tid != '0);
    assign o_stat.scan_done = (r_n == '0) || (r_st[pos_nx] == ST_READY);

    always_comb begin
        run_sched = 1'b0;
        if (r_op == OP_BLOCK) run_sched = 1'b1;
        if (r_op == OP_SLEEP && !(r_wk < r_now)) run_sched = 1'b1;
        if (r_op == OP_SCHED) run_sched = 1'b1;
        cur_after = r_cur;
    end

    always_comb begin
        need_find = (r_op == OP_UNBLOCK) || (r_op == OP_SOFT);
        need_scan = 1'b0;
        if (run_sched) begin
            if (r_op == OP_SCHED || r_idle) need_scan = (r_live != '0);
            else need_scan = (live_dn != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MaxTasks; k++) begin
                r_id[k] <= '0;
                r_st[k] <= '0;
            end
            r_id[0] <= 16'd1;
            r_id[1] <= 16'd2;
            r_st[0] <= ST_RUNNING;
            r_st[1] <= ST_READY;
            r_used <= CntW'(2);
            r_cur <= '0;
            r_idle <= 1'b0;
            r_live <= CntW'(2);
            r_last <= 16'd2;
            r_op <= '0;
            r_n <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op <= i_opcode;
                r_tid <= i_task_id;
                r_code <= i_state_code;
                r_wk <= i_wake_time;
                r_now <= i_now_tick;
                r_status <= STS_OK;
                r_new <= '0;
                r_was_idle <= r_idle;
                r_was_slot <= r_cur;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_CREATE: begin
                        if (r_code != ST_IDLE) begin
                            if (r_used >= CntW'(MaxTasks)) begin
                                r_status <= STS_FULL;
                            end else begin
                                r_last <= r_last + 1'b1;
                                r_new <= r_last + 1'b1;
                                r_id[used_lo] <= r_last + 1'b1;
                                r_st[used_lo] <= r_code;
                                r_wake[used_lo] <= '0;
                                r_used <= r_used + 1'b1;
                                if (r_code == ST_READY) r_live <= live_up;
                            end
                        end
                    end
                    OP_BLOCK, OP_SLEEP, OP_SCHED: begin
                        if (r_op == OP_SLEEP && r_wk < r_now) begin
                            r_status <= STS_PAST;
                        end else begin
                            if (!r_idle) begin
                                if (r_op == OP_SCHED) begin
                                    if (need_scan && r_st[r_cur] == ST_RUNNING) begin
                                        r_st[r_cur] <= ST_READY;
                                    end
                                end else begin
                                    r_live <= live_dn;
                                    if (r_op == OP_SLEEP) r_wake[r_cur] <= r_wk;
                                    if (need_scan && blk_code == ST_RUNNING) begin
                                        r_st[r_cur] <= ST_READY;
                                    end else begin
                                        r_st[r_cur] <= blk_code;
                                    end
                                end
                            end
                            if (!need_scan) begin
                                r_idle <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (need_find) begin
                    r_pos <= used_m1;
                    r_n <= r_used;
                end
                if (need_scan) begin
                    r_pos <= r_idle ? used_lo : r_cur;
                    r_n <= r_used;
                end
            end
            if (i_cmd.find_step) begin
                if (r_n == '0) begin
                    r_status <= STS_NOT_FOUND;
                end else if (r_id[r_pos] == r_tid && r_tid != '0) begin
                    if (r_op == OP_UNBLOCK) begin
                        r_live <= live_up;
                        if (!r_idle && r_cur != r_pos) r_st[r_cur] <= ST_READY;
                        r_st[r_pos] <= ST_RUNNING;
                        r_cur <= r_pos;
                        r_idle <= 1'b0;
                    end else if (r_st[r_pos] == ST_READY || r_st[r_pos] == ST_RUNNING) begin
                        r_status <= STS_ALREADY;
                    end else begin
                        r_live <= live_up;
                        r_st[r_pos] <= ST_READY;
                    end
                end else begin
                    r_pos <= r_pos - 1'b1;
                    r_n <= r_n - 1'b1;
                end
            end
            if (i_cmd.scan_step) begin
                if (r_n == '0) begin
                    r_status <= STS_NO_READY;
                    r_idle <= 1'b1;
                end else if (r_st[pos_nx] == ST_READY) begin
                    r_st[pos_nx] <= ST_RUNNING;
                    r_cur <= pos_nx;
                    r_idle <= 1'b0;
                end else begin
                    r_pos <= pos_nx;
                    r_n <= r_n - 1'b1;
                end
            end
        end
    end

    assign o_status = r_status;
    assign o_running_id = r_idle ? '0 : r_id[cur_after];
    assign o_switched = (r_was_idle != r_idle) || (!r_idle && r_was_slot != r_cur);
    assign o_new_id = r_new;

endmodule

// ===== src/round_robin_task_scheduler_unit.sv =====
// Task table of 16 slots with a round-robin pick of the next ready task and
// an idle task (id 0) as fallback. One word in gives one word out. A word
// passes through decode and then, where its opcode needs it, an id lookup
// (unblock, soft unblock) or a ready scan (block, sleep, schedule) before its
// result is written; the lookup and the scan walk the slot table one entry a
// cycle. The next word is accepted as soon as the result sits in the output
// register; that word then holds in its last cycle until the waiting result
// is taken.
module round_robin_task_scheduler_unit import rrts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], task_id[18:3], state_code[22:19], wake_time[54:23],
    // now_tick[86:55], zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], running_id[18:3], switched[19], new_id[35:20], zero fill
    output logic [39:0] m_axis_tdata
);

    t_cmd        cmd;
    t_stat       stat;
    logic        r_ovalid;
    logic [39:0] r_odata;
    logic [2:0]  status;
    logic [15:0] running_id;
    logic        switched;
    logic [15:0] new_id;
    logic        in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_busy (r_ovalid && !m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (s_axis_tready)
    );

    rrts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (s_axis_tdata[2:0]),
        .i_task_id    (s_axis_tdata[18:3]),
        .i_state_code (s_axis_tdata[22:19]),
        .i_wake_time  (s_axis_tdata[54:23]),
        .i_now_tick   (s_axis_tdata[86:55]),
        .o_stat       (stat),
        .o_status     (status),
        .o_running_id (running_id),
        .o_switched   (switched),
        .o_new_id     (new_id)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) r_odata <= {4'd0, new_id, switched, running_id, status};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !s_axis_tready)
        else $error("input accepted during scan");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("result lost");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= STS_PAST)
        else $error("bad status");

endmodule
